FILE: src/hpq_pkg.sv
package hpq_pkg;

  localparam int CAPACITY  = 64;
  localparam int ID_BITS   = 6;
  localparam int KEY_BITS  = 32;
  localparam int POS_BITS  = 7;
  localparam int ADDR_BITS = 6;
  localparam int ID_COUNT  = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } slot_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    slot_t                data;
  } slot_wr_t;

  typedef struct packed {
    logic                set_en;
    logic [ID_BITS-1:0]  set_id;
    logic [POS_BITS-1:0] set_pos;
    logic                clr_en;
    logic [ID_BITS-1:0]  clr_id;
  } pos_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_UP,
    S_UPC,
    S_POP,
    S_POPL,
    S_DN,
    S_DNC,
    S_TOP,
    S_DONE
  } state_t;

endpackage

FILE: src/hpq_slots.sv
module hpq_slots (
  input  logic                            clk,
  input  hpq_pkg::slot_wr_t               wr,
  input  logic                            re_a,
  input  logic [hpq_pkg::ADDR_BITS-1:0]   addr_a,
  input  logic                            re_b,
  input  logic [hpq_pkg::ADDR_BITS-1:0]   addr_b,
  output hpq_pkg::slot_t                  rd_a,
  output hpq_pkg::slot_t                  rd_b
);

  hpq_pkg::slot_t mem [hpq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (re_a) begin
      rd_a <= mem[addr_a];
    end
    if (re_b) begin
      rd_b <= mem[addr_b];
    end
  end

endmodule

FILE: src/hpq_posmap.sv
module hpq_posmap (
  input  logic                           clk,
  input  logic                           rst,
  input  hpq_pkg::pos_wr_t               wr,
  input  logic                           re,
  input  logic [hpq_pkg::ID_BITS-1:0]    rd_id,
  output logic [hpq_pkg::POS_BITS-1:0]   rd_pos
);

  logic [hpq_pkg::POS_BITS-1:0] mem [hpq_pkg::ID_COUNT];
  logic [hpq_pkg::ID_COUNT-1:0] present;

  always_ff @(posedge clk) begin
    if (wr.set_en) begin
      mem[wr.set_id] <= wr.set_pos;
    end
    if (re) begin
      rd_pos <= present[rd_id] ? mem[rd_id] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (wr.clr_en) begin
        present[wr.clr_id] <= 1'b0;
      end
      if (wr.set_en) begin
        present[wr.set_id] <= 1'b1;
      end
    end
  end

endmodule

FILE: src/indexed_max_priority_queue.sv
// channel  | handshake           | payload
// input    | in_valid, in_ready  | cmd, proc_id, key
// output   | out_valid, out_ready| top_valid, top_id, top_key, count, status
//
// one command at a time; insert lifts the new entry up the heap; remove
// lifts its entry to the root and then pops; pop sifts the last entry down
// a level up costs one slot read and one compare, a level down two reads
// rst clears the position valid bits and count; no clearing pass
// a held result does not block the next transfer into the input
module indexed_max_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [hpq_pkg::ID_BITS-1:0]   proc_id,
  input  logic [hpq_pkg::KEY_BITS-1:0]  key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          top_valid,
  output logic [hpq_pkg::ID_BITS-1:0]   top_id,
  output logic [hpq_pkg::KEY_BITS-1:0]  top_key,
  output logic [hpq_pkg::POS_BITS-1:0]  count,
  output logic [2:0]                    status
);

  hpq_pkg::state_t state, state_next;

  logic [1:0]                   cmd_q;
  logic [hpq_pkg::ID_BITS-1:0]  id_q;
  logic [hpq_pkg::KEY_BITS-1:0] key_q;
  logic [hpq_pkg::POS_BITS-1:0] cnt, cnt_next;
  logic [hpq_pkg::POS_BITS-1:0] hole, hole_next;
  hpq_pkg::slot_t               cur, cur_next;
  logic                         forced, forced_next;
  logic [2:0]                   stat_q, stat_next;

  hpq_pkg::slot_wr_t            slot_wr;
  hpq_pkg::pos_wr_t             pos_wr;
  logic                         re_a, re_b, pos_re;
  logic [hpq_pkg::ADDR_BITS-1:0] addr_a, addr_b;
  hpq_pkg::slot_t               rd_a, rd_b;
  logic [hpq_pkg::POS_BITS-1:0] pos_rd;

  logic                         accept;
  logic                         out_load;
  logic [hpq_pkg::POS_BITS-1:0] parent;
  logic [hpq_pkg::POS_BITS:0]   c1;
  logic [hpq_pkg::POS_BITS:0]   c2;
  logic                         c1_out;
  logic                         up_move;
  logic                         take_b, take_a;
  logic [hpq_pkg::POS_BITS-1:0] last_addr;

  function automatic logic [hpq_pkg::ADDR_BITS-1:0] last_hole_addr(
    input logic [hpq_pkg::POS_BITS-1:0] p
  );
    logic [hpq_pkg::POS_BITS-1:0] a;
    a = p - 1'b1;
    return a[hpq_pkg::ADDR_BITS-1:0];
  endfunction

  hpq_slots u_slots (
    .clk    (clk),
    .wr     (slot_wr),
    .re_a   (re_a),
    .addr_a (addr_a),
    .re_b   (re_b),
    .addr_b (addr_b),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  hpq_posmap u_posmap (
    .clk    (clk),
    .rst    (rst),
    .wr     (pos_wr),
    .re     (pos_re),
    .rd_id  (proc_id),
    .rd_pos (pos_rd)
  );

  assign in_ready  = (state == hpq_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == hpq_pkg::S_DONE) && (!out_valid || out_ready);
  assign parent    = hole >> 1;
  assign c1        = {hole, 1'b0};
  assign c2        = c1 + 1'b1;
  assign c1_out    = c1 > {1'b0, cnt};
  assign up_move   = forced || (rd_a.key < cur.key);
  assign take_b    = (c2 <= {1'b0, cnt}) && (rd_a.key < rd_b.key) && (cur.key < rd_b.key);
  assign take_a    = cur.key < rd_a.key;
  assign last_addr = cnt - 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hpq_pkg::S_IDLE: begin
        if (accept) state_next = hpq_pkg::S_LOOK;
      end
      hpq_pkg::S_LOOK: begin
        case (cmd_q)
          hpq_pkg::CMD_INSERT: begin
            if (cnt == 7'(hpq_pkg::CAPACITY) || pos_rd != '0) state_next = hpq_pkg::S_TOP;
            else state_next = hpq_pkg::S_UP;
          end
          hpq_pkg::CMD_POP: begin
            if (cnt == '0) state_next = hpq_pkg::S_TOP;
            else state_next = hpq_pkg::S_POP;
          end
          hpq_pkg::CMD_REMOVE: begin
            if (pos_rd == '0 || pos_rd > cnt) state_next = hpq_pkg::S_TOP;
            else state_next = hpq_pkg::S_UP;
          end
          default: state_next = hpq_pkg::S_TOP;
        endcase
      end
      hpq_pkg::S_UP: begin
        if (hole == 7'd1) state_next = forced ? hpq_pkg::S_POP : hpq_pkg::S_TOP;
        else state_next = hpq_pkg::S_UPC;
      end
      hpq_pkg::S_UPC: begin
        state_next = up_move ? hpq_pkg::S_UP : hpq_pkg::S_TOP;
      end
      hpq_pkg::S_POP:  state_next = hpq_pkg::S_POPL;
      hpq_pkg::S_POPL: begin
        state_next = (cnt > 7'd1) ? hpq_pkg::S_DN : hpq_pkg::S_TOP;
      end
      hpq_pkg::S_DN: begin
        state_next = c1_out ? hpq_pkg::S_TOP : hpq_pkg::S_DNC;
      end
      hpq_pkg::S_DNC: begin
        state_next = (take_b || take_a) ? hpq_pkg::S_DN : hpq_pkg::S_TOP;
      end
      hpq_pkg::S_TOP:  state_next = hpq_pkg::S_DONE;
      hpq_pkg::S_DONE: begin
        if (out_load) state_next = hpq_pkg::S_IDLE;
      end
      default: state_next = hpq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_next    = cnt;
    hole_next   = hole;
    cur_next    = cur;
    forced_next = forced;
    stat_next   = stat_q;
    slot_wr     = '0;
    pos_wr      = '0;
    re_a        = 1'b0;
    re_b        = 1'b0;
    addr_a      = '0;
    addr_b      = '0;
    pos_re      = accept;
    case (state)
      hpq_pkg::S_LOOK: begin
        stat_next = hpq_pkg::ST_OK;
        case (cmd_q)
          hpq_pkg::CMD_INSERT: begin
            if (cnt == 7'(hpq_pkg::CAPACITY)) begin
              stat_next = hpq_pkg::ST_FULL;
            end else if (pos_rd != '0) begin
              stat_next = hpq_pkg::ST_DUP;
            end else begin
              cnt_next    = cnt + 1'b1;
              hole_next   = cnt + 1'b1;
              cur_next    = '{id: id_q, key: key_q};
              forced_next = 1'b0;
            end
          end
          hpq_pkg::CMD_POP: begin
            forced_next = 1'b0;
            if (cnt == '0) stat_next = hpq_pkg::ST_EMPTY;
          end
          hpq_pkg::CMD_REMOVE: begin
            if (pos_rd == '0 || pos_rd > cnt) begin
              stat_next = hpq_pkg::ST_ABSENT;
            end else begin
              hole_next   = pos_rd;
              forced_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      hpq_pkg::S_UP: begin
        if (hole == 7'd1) begin
          if (!forced) begin
            slot_wr = '{en: 1'b1, addr: '0, data: cur};
            pos_wr.set_en  = 1'b1;
            pos_wr.set_id  = cur.id;
            pos_wr.set_pos = hole;
          end
        end else begin
          re_a   = 1'b1;
          addr_a = last_hole_addr(parent);
        end
      end
      hpq_pkg::S_UPC: begin
        if (up_move) begin
          slot_wr = '{en: 1'b1, addr: last_hole_addr(hole), data: rd_a};
          pos_wr.set_en  = 1'b1;
          pos_wr.set_id  = rd_a.id;
          pos_wr.set_pos = hole;
          hole_next      = parent;
        end else begin
          slot_wr = '{en: 1'b1, addr: last_hole_addr(hole), data: cur};
          pos_wr.set_en  = 1'b1;
          pos_wr.set_id  = cur.id;
          pos_wr.set_pos = hole;
        end
      end
      hpq_pkg::S_POP: begin
        re_a   = 1'b1;
        addr_a = '0;
        re_b   = 1'b1;
        addr_b = last_addr[hpq_pkg::ADDR_BITS-1:0];
      end
      hpq_pkg::S_POPL: begin
        pos_wr.clr_en = 1'b1;
        pos_wr.clr_id = forced ? id_q : rd_a.id;
        cnt_next      = cnt - 1'b1;
        cur_next      = rd_b;
        hole_next     = 7'd1;
      end
      hpq_pkg::S_DN: begin
        if (c1_out) begin
          slot_wr = '{en: 1'b1, addr: last_hole_addr(hole), data: cur};
          pos_wr.set_en  = 1'b1;
          pos_wr.set_id  = cur.id;
          pos_wr.set_pos = hole;
        end else begin
          re_a   = 1'b1;
          addr_a = hpq_pkg::ADDR_BITS'(c1 - 1'b1);
          re_b   = 1'b1;
          addr_b = c1[hpq_pkg::ADDR_BITS-1:0];
        end
      end
      hpq_pkg::S_DNC: begin
        pos_wr.set_en  = 1'b1;
        pos_wr.set_pos = hole;
        if (take_b) begin
          slot_wr = '{en: 1'b1, addr: last_hole_addr(hole), data: rd_b};
          pos_wr.set_id = rd_b.id;
          hole_next     = c2[hpq_pkg::POS_BITS-1:0];
        end else if (take_a) begin
          slot_wr = '{en: 1'b1, addr: last_hole_addr(hole), data: rd_a};
          pos_wr.set_id = rd_a.id;
          hole_next     = c1[hpq_pkg::POS_BITS-1:0];
        end else begin
          slot_wr = '{en: 1'b1, addr: last_hole_addr(hole), data: cur};
          pos_wr.set_id = cur.id;
        end
      end
      hpq_pkg::S_TOP: begin
        re_a   = 1'b1;
        addr_a = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hpq_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      id_q  <= proc_id;
      key_q <= key;
    end
    hole   <= hole_next;
    cur    <= cur_next;
    forced <= forced_next;
    stat_q <= stat_next;
    if (out_load) begin
      top_valid <= cnt != '0;
      top_id    <= (cnt != '0) ? rd_a.id : '0;
      top_key   <= (cnt != '0) ? rd_a.key : '0;
      count     <= cnt;
      status    <= stat_q;
    end
  end

endmodule

FILE: src/hpq_check.sv
module hpq_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          top_valid,
  input logic [hpq_pkg::ID_BITS-1:0]   top_id,
  input logic [hpq_pkg::KEY_BITS-1:0]  top_key,
  input logic [hpq_pkg::POS_BITS-1:0]  count,
  input logic [2:0]                    status
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= 7'(hpq_pkg::CAPACITY))
    else $error("count above capacity");

  a_top_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> top_valid == (count != '0))
    else $error("top_valid disagrees with count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !top_valid |-> top_id == '0 && top_key == '0)
    else $error("empty result carries data");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != hpq_pkg::ST_FULL || count == 7'(hpq_pkg::CAPACITY)) &&
                  (status != hpq_pkg::ST_EMPTY || count == '0))
    else $error("status inconsistent with count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
    else $error("output transfer dropped while stalled");

endmodule

bind indexed_max_priority_queue hpq_check u_hpq_check (.*);
